// ===== rtl/ihrf_pkg.sv =====
`timescale 1ns / 1ps
package ihrf_pkg;

    localparam int RULE_SLOTS  = 4;
    localparam int RULE_W      = 35;
    localparam int RULE_IDX_W  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CFG_INDEX_W = 3;

    localparam int SUMQ_DEPTH  = 4;
    localparam int SUMQ_AW     = $clog2(SUMQ_DEPTH);
    localparam int OUTQ_DEPTH  = 2;
    localparam int OUTQ_AW     = $clog2(OUTQ_DEPTH);

    localparam logic [15:0] IP_START  = 16'd14;
    localparam logic [15:0] PROTO_POS = IP_START + 16'd9;
    localparam logic [15:0] SRC_FIRST = IP_START + 16'd12;
    localparam logic [15:0] SRC_LAST  = IP_START + 16'd15;
    localparam logic [15:0] DST_FIRST = IP_START + 16'd16;
    localparam logic [15:0] DST_LAST  = IP_START + 16'd19;
    localparam logic [15:0] POS_MAX   = 16'hFFFF;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [2:0] KIND_OFF     = 3'd0;
    localparam logic [2:0] KIND_PROTO   = 3'd1;
    localparam logic [2:0] KIND_SRCIP   = 3'd2;
    localparam logic [2:0] KIND_DSTIP   = 3'd3;
    localparam logic [2:0] KIND_SPORT   = 3'd4;
    localparam logic [2:0] KIND_DPORT   = 3'd5;
    localparam logic [2:0] KIND_ANYPORT = 3'd6;

    localparam logic [1:0] CLASS_TCP   = 2'd0;
    localparam logic [1:0] CLASS_UDP   = 2'd1;
    localparam logic [1:0] CLASS_ICMP  = 2'd2;
    localparam logic [1:0] CLASS_OTHER = 2'd3;

    localparam int CNT_SLOTS = 5;
    localparam logic [2:0] CNT_DROP = 3'd4;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } frame_t;

    typedef struct packed {
        logic        matched;
        logic [1:0]  protocol_class;
        logic [15:0] frame_bytes;
        logic [31:0] tcp_total;
        logic [31:0] udp_total;
        logic [31:0] icmp_total;
        logic [31:0] other_total;
        logic [31:0] dropped_total;
    } result_t;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] byte_count;
    } sum_t;

endpackage

// ===== rtl/ihrf_parser.sv =====
`timescale 1ns / 1ps
module ihrf_parser
    import ihrf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  frame_t in_item,
    output logic   sum_push,
    output sum_t   sum_item
);

    logic [15:0] pos_reg, pos_next;
    logic [3:0]  hw_reg, hw_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;

    logic [7:0]  b;
    logic [3:0]  words;
    logic [6:0]  port_at;
    logic [15:0] port_pos;
    logic [15:0] port_off;
    logic        port_hit;
    logic [15:0] count;
    logic [7:0]  proto_cap;
    logic [31:0] src_cap;
    logic [31:0] dst_cap;
    logic [15:0] sport_cap;
    logic [15:0] dport_cap;
    logic [3:0]  hw_cap;

    always_comb
    begin
        b         = in_item.frame_byte;
        words     = (pos_reg == IP_START) ? b[3:0] : hw_reg;
        hw_cap    = words;
        port_at   = 7'(IP_START) + {1'b0, words, 2'b00};
        port_pos  = {9'd0, port_at};
        port_off  = pos_reg - port_pos;
        port_hit  = (pos_reg >= port_pos) && (port_off < 16'd4);
        count     = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 16'd1;

        proto_cap = (pos_reg == PROTO_POS) ? b : proto_reg;
        src_cap   = (pos_reg >= SRC_FIRST && pos_reg <= SRC_LAST) ?
                    {src_reg[23:0], b} : src_reg;
        dst_cap   = (pos_reg >= DST_FIRST && pos_reg <= DST_LAST) ?
                    {dst_reg[23:0], b} : dst_reg;
        sport_cap = (port_hit && port_off[1] == 1'b0) ? {sport_reg[7:0], b} : sport_reg;
        dport_cap = (port_hit && port_off[1] == 1'b1) ? {dport_reg[7:0], b} : dport_reg;

        pos_next   = pos_reg;
        hw_next    = hw_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;

        if (in_valid)
        begin
            if (in_item.frame_last)
            begin
                pos_next   = '0;
                hw_next    = '0;
                proto_next = '0;
                src_next   = '0;
                dst_next   = '0;
                sport_next = '0;
                dport_next = '0;
            end
            else
            begin
                pos_next   = count;
                hw_next    = hw_cap;
                proto_next = proto_cap;
                src_next   = src_cap;
                dst_next   = dst_cap;
                sport_next = sport_cap;
                dport_next = dport_cap;
            end
        end

        sum_push            = in_valid && in_item.frame_last;
        sum_item.protocol   = proto_cap;
        sum_item.src_addr   = src_cap;
        sum_item.dst_addr   = dst_cap;
        sum_item.src_port   = sport_cap;
        sum_item.dst_port   = dport_cap;
        sum_item.byte_count = count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hw_reg    <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            hw_reg    <= hw_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            sport_reg <= sport_next;
            dport_reg <= dport_next;
        end
    end

endmodule

// ===== rtl/ihrf_sumq.sv =====
`timescale 1ns / 1ps
module ihrf_sumq
    import ihrf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  sum_t wr_item,
    output logic full,
    input  logic rd_en,
    output sum_t rd_item,
    output logic empty
);

    sum_t               mem [SUMQ_DEPTH];
    logic [SUMQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [SUMQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [SUMQ_AW:0]   cnt_reg, cnt_next;
    logic               do_wr;
    logic               do_rd;

    always_comb
    begin
        full        = (cnt_reg == (SUMQ_AW+1)'(SUMQ_DEPTH));
        empty       = (cnt_reg == '0);
        do_wr       = wr_en && !full;
        do_rd       = rd_en && !empty;
        wr_ptr_next = do_wr ? wr_ptr_reg + SUMQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + SUMQ_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + (SUMQ_AW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - (SUMQ_AW+1)'(1);
        end
        rd_item = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/ihrf_judge.sv =====
`timescale 1ns / 1ps
module ihrf_judge
    import ihrf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [RULE_W-1:0]      cfg_data,
    input  sum_t                   sum_item,
    input  logic                   sum_empty,
    output logic                   sum_pop,
    input  logic                   pop,
    output logic                   empty,
    output result_t                verdict
);

    logic [RULE_W-1:0]  rule_reg [RULE_SLOTS];
    logic [31:0]        cnt_reg  [CNT_SLOTS];
    logic [31:0]        cnt_next [CNT_SLOTS];
    result_t            res_mem  [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_AW:0]   oq_cnt_reg, oq_cnt_next;

    logic        cfg_hit;
    logic        has_ports;
    logic        any_on;
    logic        hit;
    logic        pass;
    logic [1:0]  cls;
    logic [2:0]  sel;
    logic [2:0]  kind;
    logic [31:0] val;
    logic [15:0] port;
    logic        do_rd;
    result_t     res;

    always_comb
    begin
        cfg_hit   = cfg_valid && ({1'b0, cfg_index} < (CFG_INDEX_W+1)'(RULE_SLOTS));
        has_ports = (sum_item.protocol == PROTO_TCP) || (sum_item.protocol == PROTO_UDP);
        any_on    = 1'b0;
        hit       = 1'b0;
        kind      = '0;
        val       = '0;
        port      = '0;
        for (int i = 0; i < RULE_SLOTS; i++)
        begin
            kind = rule_reg[i][RULE_W-1:32];
            val  = rule_reg[i][31:0];
            port = val[15:0];
            case (kind)
                KIND_PROTO:
                begin
                    any_on = 1'b1;
                    hit    = hit || (val == {24'd0, sum_item.protocol});
                end
                KIND_SRCIP:
                begin
                    any_on = 1'b1;
                    hit    = hit || (val == sum_item.src_addr);
                end
                KIND_DSTIP:
                begin
                    any_on = 1'b1;
                    hit    = hit || (val == sum_item.dst_addr);
                end
                KIND_SPORT:
                begin
                    any_on = 1'b1;
                    hit    = hit || (has_ports && port == sum_item.src_port);
                end
                KIND_DPORT:
                begin
                    any_on = 1'b1;
                    hit    = hit || (has_ports && port == sum_item.dst_port);
                end
                KIND_ANYPORT:
                begin
                    any_on = 1'b1;
                    hit    = hit || (has_ports && (port == sum_item.src_port ||
                                                   port == sum_item.dst_port));
                end
                default:
                begin
                    any_on = any_on;
                end
            endcase
        end
        pass = any_on ? hit : 1'b1;

        case (sum_item.protocol)
            PROTO_TCP:  cls = CLASS_TCP;
            PROTO_UDP:  cls = CLASS_UDP;
            PROTO_ICMP: cls = CLASS_ICMP;
            default:    cls = CLASS_OTHER;
        endcase
        sel = pass ? {1'b0, cls} : CNT_DROP;

        sum_pop = !sum_empty && (oq_cnt_reg != (OUTQ_AW+1)'(OUTQ_DEPTH));

        for (int k = 0; k < CNT_SLOTS; k++)
        begin
            cnt_next[k] = cnt_reg[k];
            if (sum_pop && sel == 3'(k) && cnt_reg[k] != 32'hFFFF_FFFF)
            begin
                cnt_next[k] = cnt_reg[k] + 32'd1;
            end
        end

        res.matched        = pass;
        res.protocol_class = cls;
        res.frame_bytes    = sum_item.byte_count;
        res.tcp_total      = cnt_next[{1'b0, CLASS_TCP}];
        res.udp_total      = cnt_next[{1'b0, CLASS_UDP}];
        res.icmp_total     = cnt_next[{1'b0, CLASS_ICMP}];
        res.other_total    = cnt_next[{1'b0, CLASS_OTHER}];
        res.dropped_total  = cnt_next[CNT_DROP];

        empty       = (oq_cnt_reg == '0);
        do_rd       = pop && !empty;
        verdict     = res_mem[rd_ptr_reg];
        wr_ptr_next = sum_pop ? wr_ptr_reg + OUTQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + OUTQ_AW'(1) : rd_ptr_reg;
        oq_cnt_next = oq_cnt_reg;
        if (sum_pop && !do_rd)
        begin
            oq_cnt_next = oq_cnt_reg + (OUTQ_AW+1)'(1);
        end
        else if (do_rd && !sum_pop)
        begin
            oq_cnt_next = oq_cnt_reg - (OUTQ_AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_pop)
        begin
            res_mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RULE_SLOTS; i++)
            begin
                rule_reg[i] <= '0;
            end
            for (int k = 0; k < CNT_SLOTS; k++)
            begin
                cnt_reg[k] <= '0;
            end
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_hit)
            begin
                rule_reg[cfg_index[RULE_IDX_W-1:0]] <= cfg_data;
            end
            for (int k = 0; k < CNT_SLOTS; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

endmodule

// ===== rtl/ipv4_header_rule_filter.sv =====
`timescale 1ns / 1ps
// Channel    Handshake                 Payload
// frame in   push / full               frame   (frame_byte, frame_last)
// verdict    pop / empty               verdict (matched, class, bytes, totals)
// config     cfg_valid / cfg_ready     cfg_index, cfg_data (35-bit rule)
//
// One frame byte is taken every cycle while full is low; the parser captures header
// fields per byte. The result for a frame passes through the 4-entry summary queue,
// then the rule check and counter update, which write it to the output queue for pop.
// Reset clears rules, counters and the per-frame capture at once; no sweep follows.
// full rises only when the summary queue fills because results are not popped.
module ipv4_header_rule_filter
    import ihrf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  frame_t                 frame,
    input  logic                   pop,
    output logic                   empty,
    output result_t                verdict,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [RULE_W-1:0]      cfg_data
);

    logic accept;
    logic sum_push;
    sum_t sum_wr;
    sum_t sum_rd;
    logic sum_empty;
    logic sum_pop;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    ihrf_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_item  (frame),
        .sum_push (sum_push),
        .sum_item (sum_wr)
    );

    ihrf_sumq u_sumq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (sum_push),
        .wr_item (sum_wr),
        .full    (full),
        .rd_en   (sum_pop),
        .rd_item (sum_rd),
        .empty   (sum_empty)
    );

    ihrf_judge u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sum_item  (sum_rd),
        .sum_empty (sum_empty),
        .sum_pop   (sum_pop),
        .pop       (pop),
        .empty     (empty),
        .verdict   (verdict)
    );

endmodule

// ===== rtl/ihrf_checker.sv =====
`timescale 1ns / 1ps
module ihrf_checker
    import ihrf_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    pop,
    input logic    empty,
    input result_t verdict
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(verdict)))
        else $error("waiting item changed before pop");

    a_drop_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !verdict.matched) |-> (verdict.dropped_total != 32'd0))
        else $error("dropped item with zero drop total");

    a_tcp_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && verdict.matched && verdict.protocol_class == CLASS_TCP)
            |-> (verdict.tcp_total != 32'd0))
        else $error("passed tcp item with zero tcp total");

    a_bytes_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (verdict.frame_bytes != 16'd0))
        else $error("item with zero frame length");

endmodule

bind ipv4_header_rule_filter ihrf_checker u_ihrf_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .pop     (pop),
    .empty   (empty),
    .verdict (verdict)
);
